// ===== rtl/lphm_pkg.sv =====
// Shared constants, codes and types of the linear-probe hash memo table.
package lphm_pkg;

    // Table geometry
    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int FILL_W   = 10;
    localparam int LIM_W    = (CNT_W > FILL_W) ? CNT_W : FILL_W;
    localparam int FP_W     = 7;
    localparam int META_W   = 8;
    localparam int KEYL_W   = 64;
    localparam int KEYH_W   = 16;

    localparam logic [FILL_W-1:0] FILL_LIMIT_RST = 10'd768;

    // Mixer constants
    localparam logic [63:0] MIX_GOLDEN = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_C1     = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_C2     = 64'h94D0_49BB_1331_11EB;

    // Opcodes
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Status codes
    localparam logic [2:0] ST_NOT_FOUND   = 3'd0;
    localparam logic [2:0] ST_FOUND_TRUE  = 3'd1;
    localparam logic [2:0] ST_FOUND_FALSE = 3'd2;
    localparam logic [2:0] ST_INSERTED    = 3'd3;
    localparam logic [2:0] ST_UPDATED     = 3'd4;
    localparam logic [2:0] ST_FULL        = 3'd5;
    localparam logic [2:0] ST_CLEARED     = 3'd6;

    // Configuration register indexes
    localparam logic CFG_KEY_WIDE   = 1'b0;
    localparam logic CFG_FILL_LIMIT = 1'b1;

    // Hash sequencer states
    typedef enum logic [2:0] {
        H_IDLE,
        H_GOLD,
        H_X30,
        H_M1,
        H_X27,
        H_M2,
        H_X31,
        H_MOD
    } hash_state_t;

    // Top-level control states
    typedef enum logic [2:0] {
        T_SWEEP,
        T_IDLE,
        T_HASH,
        T_PROBE,
        T_RESULT
    } top_state_t;

    // Hash result: home slot and fingerprint
    typedef struct packed {
        logic [IDX_W-1:0] home;
        logic [FP_W-1:0]  fp;
    } hash_res_t;

    // Slot store write request
    typedef struct packed {
        logic              meta_we;
        logic              key_low_we;
        logic              key_high_we;
        logic [IDX_W-1:0]  addr;
        logic [META_W-1:0] meta;
        logic [KEYL_W-1:0] key_low;
        logic [KEYH_W-1:0] key_high;
    } store_wr_t;

    // Slot store read data
    typedef struct packed {
        logic [META_W-1:0] meta;
        logic [KEYL_W-1:0] key_low;
        logic [KEYH_W-1:0] key_high;
    } store_rd_t;

endpackage

// ===== rtl/lphm_mul.sv =====
// Iterative 64x64 multiplier (low 64 bits) built on one 32x32 multiplier.
module lphm_mul
    import lphm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] product
);

    logic        busy_reg;
    logic [1:0]  ph_reg;
    logic        done_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [31:0] mx;
    logic [31:0] my;
    logic [63:0] mul_full;

    // Operand select per partial product; a and b hold steady while busy
    always_comb
    begin
        unique case (ph_reg)
            2'd0:
            begin
                mx = a[31:0];
                my = b[31:0];
            end
            2'd1:
            begin
                mx = a[31:0];
                my = b[63:32];
            end
            2'd2:
            begin
                mx = a[63:32];
                my = b[31:0];
            end
            default:
            begin
                mx = 32'd0;
                my = 32'd0;
            end
        endcase
    end

    assign mul_full = mx * my;

    // Phase control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ph_reg   <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                ph_reg   <= 2'd0;
            end
            else if (busy_reg)
            begin
                ph_reg <= ph_reg + 2'd1;
                if (ph_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Product register and accumulation of the previous partial product
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            prod_reg <= mul_full;
            unique case (ph_reg)
                2'd0:    acc_reg <= acc_reg;
                2'd1:    acc_reg <= prod_reg;
                default: acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
            endcase
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== rtl/lphm_hash.sv =====
// Key mixer sequencer: xor-shift steps and two multiplies (three with a wide key) on the shared multiplier.
module lphm_hash
    import lphm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [KEYL_W-1:0] key_low,
    input  logic [KEYH_W-1:0] key_high,
    input  logic              key_wide,
    output logic              done,
    output hash_res_t         result
);

    localparam bit CAP_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);
    localparam logic [IDX_W:0] CAP_R = (IDX_W + 1)'(CAPACITY);

    hash_state_t       state_reg, state_next;
    logic [63:0]       z_reg, z_next;
    logic [KEYH_W-1:0] hi_reg;
    logic [IDX_W:0]    r_reg, r_next;
    logic [5:0]        bit_reg, bit_next;
    logic              done_reg, done_next;
    logic              mul_start;
    logic [63:0]       mul_a;
    logic [63:0]       mul_b;
    logic              mul_done;
    logic [63:0]       mul_p;
    logic [IDX_W:0]    rem_shift;
    logic [FP_W-1:0]   fp_raw;

    lphm_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    // Multiplier operands by step
    always_comb
    begin
        mul_a = (state_reg == H_GOLD) ? (64'(hi_reg) + 64'd1) : z_reg;
        priority case (state_reg)
            H_GOLD:  mul_b = MIX_GOLDEN;
            H_M1:    mul_b = MIX_C1;
            default: mul_b = MIX_C2;
        endcase
    end

    // One restoring step of the remainder by capacity
    assign rem_shift = {r_reg[IDX_W-1:0], z_reg[bit_reg]};

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        z_next     = z_reg;
        r_next     = r_reg;
        bit_next   = bit_reg;
        done_next  = 1'b0;
        mul_start  = 1'b0;
        unique case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    z_next = key_low;
                    if (key_wide)
                    begin
                        mul_start  = 1'b1;
                        state_next = H_GOLD;
                    end
                    else
                    begin
                        state_next = H_X30;
                    end
                end
            end
            H_GOLD:
            begin
                if (mul_done)
                begin
                    z_next     = z_reg ^ mul_p;
                    state_next = H_X30;
                end
            end
            H_X30:
            begin
                z_next     = z_reg ^ (z_reg >> 30);
                mul_start  = 1'b1;
                state_next = H_M1;
            end
            H_M1:
            begin
                if (mul_done)
                begin
                    z_next     = mul_p;
                    state_next = H_X27;
                end
            end
            H_X27:
            begin
                z_next     = z_reg ^ (z_reg >> 27);
                mul_start  = 1'b1;
                state_next = H_M2;
            end
            H_M2:
            begin
                if (mul_done)
                begin
                    z_next     = mul_p;
                    state_next = H_X31;
                end
            end
            H_X31:
            begin
                z_next = z_reg ^ (z_reg >> 31);
                if (CAP_POW2)
                begin
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    r_next     = '0;
                    bit_next   = 6'd63;
                    state_next = H_MOD;
                end
            end
            H_MOD:
            begin
                r_next = (rem_shift >= CAP_R) ? (rem_shift - CAP_R) : rem_shift;
                if (bit_reg == 6'd0)
                begin
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    bit_next = bit_reg - 6'd1;
                end
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        z_reg   <= z_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
        if (start && (state_reg == H_IDLE))
        begin
            hi_reg <= key_high;
        end
    end

    // Fingerprint from the top bits, never zero
    assign fp_raw      = z_reg[63 -: FP_W];
    assign result.fp   = (fp_raw == '0) ? FP_W'(1) : fp_raw;
    assign result.home = CAP_POW2 ? z_reg[IDX_W-1:0] : r_reg[IDX_W-1:0];
    assign done        = done_reg;

endmodule

// ===== rtl/lphm_store.sv =====
// Slot store: meta, low key and high key memories with one registered read port.
module lphm_store
    import lphm_pkg::*;
(
    input  logic             clk,
    input  logic [IDX_W-1:0] rd_addr,
    input  store_wr_t        wr,
    output store_rd_t        rd
);

    logic [META_W-1:0] meta_mem     [CAPACITY];
    logic [KEYL_W-1:0] key_low_mem  [CAPACITY];
    logic [KEYH_W-1:0] key_high_mem [CAPACITY];

    // Writes
    always_ff @(posedge clk)
    begin
        if (wr.meta_we)
        begin
            meta_mem[wr.addr] <= wr.meta;
        end
        if (wr.key_low_we)
        begin
            key_low_mem[wr.addr] <= wr.key_low;
        end
        if (wr.key_high_we)
        begin
            key_high_mem[wr.addr] <= wr.key_high;
        end
    end

    // Registered reads
    always_ff @(posedge clk)
    begin
        rd.meta     <= meta_mem[rd_addr];
        rd.key_low  <= key_low_mem[rd_addr];
        rd.key_high <= key_high_mem[rd_addr];
    end

endmodule

// ===== rtl/linear_probe_hash_memo_table_unit.sv =====
// Top level of the linear-probe hash memo table: control sequencer, config and handshakes.
//
// Fixed-capacity map from a 64-bit (or 80-bit when key_wide is set) key to one
// boolean, open addressing with linear probing over CAPACITY slots. One command
// is worked at a time; cmd_stall is high until it is done. A lookup or insert
// first runs the key mixer, two 64-bit multiplies (three in wide mode, where
// key_high is folded in first) done as 32x32 partial products on one shared
// multiplier, followed by a serial remainder if CAPACITY is not a power of two.
// Then the probe walks slots at one memory read per cycle, and the result state
// posts the response. A clear sweeps the meta memory one slot per cycle. After
// reset the same sweep runs before the first command is taken; configuration
// writes are taken at any time. The response sits in an output register, so the
// next command can be accepted while it waits to transfer.
module linear_probe_hash_memo_table_unit
    import lphm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // command channel
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  logic [1:0]        opcode,
    input  logic [KEYL_W-1:0] key_low,
    input  logic [KEYH_W-1:0] key_high,
    input  logic              value,
    // response channel
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic [2:0]        status,
    // configuration channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [FILL_W-1:0] cfg_data
);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
    localparam logic [LIM_W-1:0] LIM_CAP  = LIM_W'(CAPACITY - 1);

    top_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  probe_reg, probe_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  clr_addr_reg, clr_addr_next;
    logic              clr_rsp_reg, clr_rsp_next;
    logic [2:0]        status_reg, status_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [2:0]        rsp_status_reg, rsp_status_next;
    logic              key_wide_reg;
    logic [FILL_W-1:0] fill_limit_reg;

    logic [1:0]        op_reg;
    logic [KEYL_W-1:0] key_low_reg;
    logic [KEYH_W-1:0] key_high_reg;
    logic              val_reg;
    logic [FP_W-1:0]   fp_reg;

    logic              cmd_fire;
    logic              hash_start;
    logic              hash_done;
    hash_res_t         hash_res;
    store_wr_t         wr;
    store_rd_t         rd;

    logic [LIM_W-1:0]  fill_ext;
    logic [LIM_W-1:0]  lim;
    logic              at_limit;
    logic              slot_empty;
    logic              key_match;
    logic              fp_match;
    logic [META_W-1:0] new_meta;
    logic [IDX_W-1:0]  idx_inc;

    assign cmd_stall = (state_reg != T_IDLE);
    assign cmd_fire  = cmd_valid && !cmd_stall;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign status    = rsp_status_reg;

    lphm_hash u_hash (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (hash_start),
        .key_low  (key_low),
        .key_high (key_high),
        .key_wide (key_wide_reg),
        .done     (hash_done),
        .result   (hash_res)
    );

    lphm_store u_store (
        .clk     (clk),
        .rd_addr (idx_next),
        .wr      (wr),
        .rd      (rd)
    );

    // Effective fill limit, one slot always left empty
    assign fill_ext = LIM_W'(fill_limit_reg);
    assign lim      = (fill_ext > LIM_CAP) ? LIM_CAP : fill_ext;
    assign at_limit = (LIM_W'(count_reg) >= lim);

    // Slot compare on the registered read data
    assign slot_empty = (rd.meta == '0);
    assign fp_match   = (rd.meta[FP_W-1:0] == fp_reg);
    assign key_match  = (rd.key_low == key_low_reg)
                        && (!key_wide_reg || (rd.key_high == key_high_reg));
    assign new_meta   = {val_reg, fp_reg};
    assign idx_inc    = (idx_reg == IDX_LAST) ? '0 : (idx_reg + IDX_W'(1));

    // Next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        probe_next      = probe_reg;
        count_next      = count_reg;
        clr_addr_next   = clr_addr_reg;
        clr_rsp_next    = clr_rsp_reg;
        status_next     = status_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_status_next = rsp_status_reg;
        hash_start      = 1'b0;
        wr              = '0;
        wr.addr         = idx_reg;
        wr.meta         = new_meta;
        wr.key_low      = key_low_reg;
        wr.key_high     = key_high_reg;
        unique case (state_reg)
            T_SWEEP:
            begin
                wr.meta_we = 1'b1;
                wr.addr    = clr_addr_reg;
                wr.meta    = '0;
                if (clr_addr_reg == IDX_LAST)
                begin
                    clr_addr_next = '0;
                    if (clr_rsp_reg)
                    begin
                        clr_rsp_next = 1'b0;
                        status_next  = ST_CLEARED;
                        state_next   = T_RESULT;
                    end
                    else
                    begin
                        state_next = T_IDLE;
                    end
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + IDX_W'(1);
                end
            end
            T_IDLE:
            begin
                if (cmd_fire)
                begin
                    priority case (opcode)
                        OP_LOOKUP, OP_INSERT:
                        begin
                            hash_start = 1'b1;
                            state_next = T_HASH;
                        end
                        OP_CLEAR:
                        begin
                            count_next    = '0;
                            clr_addr_next = '0;
                            clr_rsp_next  = 1'b1;
                            state_next    = T_SWEEP;
                        end
                        default:
                        begin
                            status_next = ST_NOT_FOUND;
                            state_next  = T_RESULT;
                        end
                    endcase
                end
            end
            T_HASH:
            begin
                if (hash_done)
                begin
                    idx_next   = hash_res.home;
                    probe_next = '0;
                    state_next = T_PROBE;
                end
            end
            T_PROBE:
            begin
                if (op_reg == OP_INSERT)
                begin
                    if (slot_empty)
                    begin
                        if (at_limit)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            wr.meta_we     = 1'b1;
                            wr.key_low_we  = 1'b1;
                            wr.key_high_we = key_wide_reg;
                            count_next     = count_reg + CNT_W'(1);
                            status_next    = ST_INSERTED;
                        end
                        state_next = T_RESULT;
                    end
                    else if (key_match)
                    begin
                        wr.meta_we  = 1'b1;
                        status_next = ST_UPDATED;
                        state_next  = T_RESULT;
                    end
                    else if (probe_reg == IDX_LAST)
                    begin
                        status_next = ST_FULL;
                        state_next  = T_RESULT;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        probe_next = probe_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    if (slot_empty)
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = T_RESULT;
                    end
                    else if (fp_match && key_match)
                    begin
                        status_next = rd.meta[META_W-1] ? ST_FOUND_TRUE : ST_FOUND_FALSE;
                        state_next  = T_RESULT;
                    end
                    else if (probe_reg == IDX_LAST)
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = T_RESULT;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        probe_next = probe_reg + IDX_W'(1);
                    end
                end
            end
            T_RESULT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    state_next      = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_SWEEP;
            count_reg     <= '0;
            clr_addr_reg  <= '0;
            clr_rsp_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            clr_addr_reg  <= clr_addr_next;
            clr_rsp_reg   <= clr_rsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_wide_reg   <= 1'b0;
            fill_limit_reg <= FILL_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_KEY_WIDE:   key_wide_reg   <= cfg_data[0];
                CFG_FILL_LIMIT: fill_limit_reg <= cfg_data;
                default:        key_wide_reg   <= key_wide_reg;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        probe_reg      <= probe_next;
        status_reg     <= status_next;
        rsp_status_reg <= rsp_status_next;
        if (cmd_fire)
        begin
            op_reg       <= opcode;
            key_low_reg  <= key_low;
            key_high_reg <= key_high;
            val_reg      <= value;
        end
        if ((state_reg == T_HASH) && hash_done)
        begin
            fp_reg <= hash_res.fp;
        end
    end

endmodule
